// ----- rtl/cpm_pkg.sv -----
// Shared types and constants for the capture period meter.
package cpm_pkg;

   // Request opcodes; the unused code behaves as a status query
   typedef enum logic [1:0] {
      OP_CAPTURE = 2'd0,
      OP_TICK    = 2'd1,
      OP_QUERY   = 2'd2
   } cpm_op_type;

   // Configuration register indexes
   localparam logic [1:0] CSR_CLOCK_HZ  = 2'd0;
   localparam logic [1:0] CSR_PRESCALER = 2'd1;
   localparam logic [1:0] CSR_TIMEOUT   = 2'd2;

   localparam int unsigned CLOCK_W    = 27;
   localparam int unsigned PRESC_W    = 11;
   localparam int unsigned TIMEOUT_W  = 16;
   localparam int unsigned CSR_DATA_W = 27;
   localparam int unsigned CSR_IDX_W  = 2;

   localparam int unsigned CAP_W    = 16;
   localparam int unsigned STAMP_W  = 32;
   localparam int unsigned PERIOD_W = 32;
   localparam int unsigned FREQ_W   = 32;

   // Captures below this value may carry an unhandled overflow
   localparam logic [CAP_W-1:0] EARLY_LIMIT = 16'h7FFF;

   localparam logic [CLOCK_W-1:0]   CLOCK_HZ_RESET  = 27'd16000000;
   localparam logic [PRESC_W-1:0]   PRESCALER_RESET = 11'd64;
   localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET   = 16'd4;

   // Job queue between request handling and frequency unit
   localparam int unsigned QDEPTH = 4;
   localparam int unsigned QPTR_W = 2;

   typedef struct packed {
      logic [PERIOD_W-1:0] period;
      logic                stalled;
   } cpm_job_type;

   typedef struct packed {
      logic        push;
      cpm_job_type job;
   } cpm_push_type;

   typedef struct packed {
      logic empty;
      logic full;
   } cpm_qstat_type;

endpackage

// ----- rtl/cpm_front.sv -----
// Request handling: timestamp extension, period and stall tracking.
module cpm_front (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_opcode,
   input  logic [cpm_pkg::CAP_W-1:0]       req_capture_value,
   input  logic                            req_overflow_pending,
   input  logic [cpm_pkg::TIMEOUT_W-1:0]   timeout,
   input  cpm_pkg::cpm_qstat_type          q_stat,
   output cpm_pkg::cpm_push_type           q_push
);
   import cpm_pkg::*;

   logic [CAP_W-1:0]     oc_ff, oc_in;
   logic [STAMP_W-1:0]   prev_ff, prev_in;
   logic [PERIOD_W-1:0]  period_ff, period_in;
   logic [TIMEOUT_W-1:0] ticks_ff, ticks_in;
   logic                 stall_ff, stall_in;
   logic                 accept;
   logic [CAP_W-1:0]     oc_cap;
   logic [STAMP_W-1:0]   stamp;
   logic [TIMEOUT_W-1:0] ticks_inc;
   cpm_op_type           op;

   assign req_ready = !q_stat.full;
   assign accept    = req_valid && req_ready;
   assign op        = cpm_op_type'(req_opcode);

   // Extend the capture to a full timestamp, folding in an early overflow
   assign oc_cap = (req_overflow_pending && (req_capture_value < EARLY_LIMIT))
                   ? oc_ff + 1'b1 : oc_ff;
   assign stamp     = {oc_cap, req_capture_value};
   assign ticks_inc = ticks_ff + 1'b1;

   // Compute next tracking state for the request
   always_comb begin
      oc_in     = oc_ff;
      prev_in   = prev_ff;
      period_in = period_ff;
      ticks_in  = ticks_ff;
      stall_in  = stall_ff;
      if (accept) begin
         unique case (op)
            OP_CAPTURE: begin
               oc_in = oc_cap;
               if (!stall_ff) begin
                  period_in = stamp - prev_ff;
               end else begin
                  stall_in = 1'b0;
               end
               prev_in  = stamp;
               ticks_in = '0;
            end
            OP_TICK: begin
               oc_in = oc_ff + 1'b1;
               if (!stall_ff) begin
                  ticks_in = ticks_inc;
                  if (ticks_inc >= timeout) begin
                     stall_in  = 1'b1;
                     period_in = '0;
                  end
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Hand every request's outcome to the frequency unit
   assign q_push.push        = accept;
   assign q_push.job.period  = period_in;
   assign q_push.job.stalled = stall_in;

   // Hold tracking state
   always_ff @(posedge clock) begin
      if (reset) begin
         oc_ff     <= '0;
         prev_ff   <= '0;
         period_ff <= '0;
         ticks_ff  <= '0;
         stall_ff  <= 1'b1;
      end else begin
         oc_ff     <= oc_in;
         prev_ff   <= prev_in;
         period_ff <= period_in;
         ticks_ff  <= ticks_in;
         stall_ff  <= stall_in;
      end
   end

endmodule

// ----- rtl/cpm_queue.sv -----
// Small job queue between request handling and the frequency unit.
module cpm_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  cpm_pkg::cpm_push_type  q_push,
   input  logic                   q_pop,
   output cpm_pkg::cpm_qstat_type q_stat,
   output cpm_pkg::cpm_job_type   q_head
);
   import cpm_pkg::*;

   cpm_job_type       entry_ff [QDEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]   count_ff, count_in;
   logic              do_push;
   logic              do_pop;

   assign q_stat.empty = (count_ff == '0);
   assign q_stat.full  = (count_ff == (QPTR_W+1)'(QDEPTH));
   assign q_head       = entry_ff[rd_ptr_ff];

   assign do_push = q_push.push && !q_stat.full;
   assign do_pop  = q_pop && !q_stat.empty;

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Store entries
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= q_push.job;
      end
   end

endmodule

// ----- rtl/cpm_freq.sv -----
// Frequency unit: Q24.8 frequency by a bit-serial restoring divider.
module cpm_freq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [cpm_pkg::CLOCK_W-1:0]   clock_hz,
   input  logic [cpm_pkg::PRESC_W-1:0]   prescaler,
   input  cpm_pkg::cpm_qstat_type        q_stat,
   input  cpm_pkg::cpm_job_type          q_head,
   output logic                          q_pop,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic [cpm_pkg::PERIOD_W-1:0]  rsp_period_ticks,
   output logic                          rsp_stalled,
   output logic [cpm_pkg::FREQ_W-1:0]    rsp_frequency_q8
);
   import cpm_pkg::*;

   localparam int unsigned NUM_W = CLOCK_W + 8;
   localparam int unsigned DEN_W = PRESC_W + PERIOD_W;
   localparam int unsigned CNT_W = $clog2(NUM_W);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_OUT
   } state_type;

   state_type          state_ff;
   cpm_job_type        job_ff;
   logic [DEN_W-1:0]   den_ff;
   logic [DEN_W-1:0]   rem_ff;
   logic [NUM_W-1:0]   num_ff;
   logic [NUM_W-1:0]   quot_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic [FREQ_W-1:0]  freq_ff;
   logic               valid_ff;
   logic [DEN_W:0]     trial;
   logic [DEN_W:0]     diff;
   logic               fits;
   logic [NUM_W-1:0]   quot_next;

   // One restoring division step
   assign trial     = {rem_ff, num_ff[NUM_W-1]};
   assign diff      = trial - {1'b0, den_ff};
   assign fits      = (trial >= {1'b0, den_ff});
   assign quot_next = {quot_ff[NUM_W-2:0], fits};

   assign q_pop            = (state_ff == ST_IDLE) && !q_stat.empty;
   assign rsp_valid        = valid_ff;
   assign rsp_period_ticks = job_ff.period;
   assign rsp_stalled      = job_ff.stalled;
   assign rsp_frequency_q8 = freq_ff;

   // Sequence: take job, form divisor, divide unless the result is already known, present response
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (!q_stat.empty) begin
                  job_ff   <= q_head;
                  state_ff <= ST_MUL;
               end
            end
            ST_MUL: begin
               den_ff  <= DEN_W'(prescaler) * DEN_W'(job_ff.period);
               rem_ff  <= '0;
               num_ff  <= {clock_hz, 8'd0};
               quot_ff <= '0;
               cnt_ff  <= CNT_W'(NUM_W - 1);
               if (job_ff.stalled || (job_ff.period == '0)) begin
                  freq_ff  <= '0;
                  valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else if (prescaler == '0) begin
                  freq_ff  <= '1;
                  valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  state_ff <= ST_DIV;
               end
            end
            ST_DIV: begin
               rem_ff  <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
               num_ff  <= {num_ff[NUM_W-2:0], 1'b0};
               quot_ff <= quot_next;
               if (cnt_ff == '0) begin
                  // Saturate quotients that overflow 32 bits
                  freq_ff  <= (|quot_next[NUM_W-1:FREQ_W]) ? '1 : quot_next[FREQ_W-1:0];
                  valid_ff <= 1'b1;
                  state_ff <= ST_OUT;
               end else begin
                  cnt_ff <= cnt_ff - 1'b1;
               end
            end
            ST_OUT: begin
               if (rsp_ready) begin
                  valid_ff <= 1'b0;
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

endmodule

// ----- rtl/capture_period_meter.sv -----
// Top level of the capture period meter.
//
//  channel | ports                                    | transfer
//  --------+------------------------------------------+------------------------
//  request | req_valid/req_ready, opcode, capture,    | valid & ready
//          | overflow_pending                         |
//  result  | rsp_valid/rsp_ready, period, stalled,    | valid & ready
//          | frequency_q8                             |
//  config  | csr_write_enable, csr_index, csr_data    | write enable, no wait
//
// Each request updates the tracking state on the cycle it is accepted and
// queues a job; the frequency unit then takes each job in turn: it picks it
// up, forms the divisor by a multiply, runs the bit-serial divider (skipped
// for stalled, zero-period or zero-prescaler jobs) and presents the response.
// It takes no new job until that response is taken, so a response that waits
// holds the frequency unit; the four-entry job queue lets requests keep
// flowing until it fills. Reset is synchronous and needs no clearing pass.
module capture_period_meter (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [1:0]                      req_opcode,
   input  logic [cpm_pkg::CAP_W-1:0]       req_capture_value,
   input  logic                            req_overflow_pending,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [cpm_pkg::PERIOD_W-1:0]    rsp_period_ticks,
   output logic                            rsp_stalled,
   output logic [cpm_pkg::FREQ_W-1:0]      rsp_frequency_q8,
   input  logic                            csr_write_enable,
   input  logic [cpm_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [cpm_pkg::CSR_DATA_W-1:0]  csr_data
);
   import cpm_pkg::*;

   logic [CLOCK_W-1:0]   clock_hz_ff;
   logic [PRESC_W-1:0]   prescaler_ff;
   logic [TIMEOUT_W-1:0] timeout_ff;
   cpm_push_type         q_push;
   cpm_qstat_type        q_stat;
   cpm_job_type          q_head;
   logic                 q_pop;

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clock_hz_ff  <= CLOCK_HZ_RESET;
         prescaler_ff <= PRESCALER_RESET;
         timeout_ff   <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_CLOCK_HZ:  clock_hz_ff  <= csr_data[CLOCK_W-1:0];
            CSR_PRESCALER: prescaler_ff <= csr_data[PRESC_W-1:0];
            CSR_TIMEOUT:   timeout_ff   <= csr_data[TIMEOUT_W-1:0];
            default: begin
            end
         endcase
      end
   end

   cpm_front u_front (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_opcode           (req_opcode),
      .req_capture_value    (req_capture_value),
      .req_overflow_pending (req_overflow_pending),
      .timeout              (timeout_ff),
      .q_stat               (q_stat),
      .q_push               (q_push)
   );

   cpm_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .q_push (q_push),
      .q_pop  (q_pop),
      .q_stat (q_stat),
      .q_head (q_head)
   );

   cpm_freq u_freq (
      .clock            (clock),
      .reset            (reset),
      .clock_hz         (clock_hz_ff),
      .prescaler        (prescaler_ff),
      .q_stat           (q_stat),
      .q_head           (q_head),
      .q_pop            (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_period_ticks (rsp_period_ticks),
      .rsp_stalled      (rsp_stalled),
      .rsp_frequency_q8 (rsp_frequency_q8)
   );

   // A request is never pushed into a full queue
   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      q_push.push |-> !q_stat.full)
      else $error("request pushed into full job queue");

   // A stalled response reports no frequency
   a_stall_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stalled) |-> (rsp_frequency_q8 == '0))
      else $error("stalled response with nonzero frequency");

   // A zero period reports no frequency
   a_period_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_period_ticks == '0)) |-> (rsp_frequency_q8 == '0))
      else $error("zero period with nonzero frequency");

   // A pop only happens while no response is pending
   a_pop_idle: assert property (@(posedge clock) disable iff (reset)
      q_pop |-> (!rsp_valid && !q_stat.empty))
      else $error("job taken while response pending or queue empty");

endmodule
